// ----- design/overlapping_tile_grid_generator_assert.svh -----
// Assertion macros for the overlapping tile grid generator.
`ifndef OVERLAPPING_TILE_GRID_GENERATOR_ASSERT_SVH
`define OVERLAPPING_TILE_GRID_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// Checks that the consequent holds in the same cycle as the antecedent.
`define OTG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define OTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define OTG_ASSERT_SAME(label, clk, rst, ante, cons)
`define OTG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/otg_pkg.sv -----
// Shared types and constants of the overlapping tile grid generator.
`timescale 1ns / 1ps

package otg_pkg;

   // Field widths.
   localparam int unsigned SizeWidth    = 13;
   localparam int unsigned NominalWidth = 12;
   localparam int unsigned CountWidth   = 4;
   localparam int unsigned StepWidth    = 14;
   localparam int unsigned TileNumWidth = 6;
   localparam int unsigned DivWidth     = SizeWidth;
   localparam int unsigned ThirdWidth   = NominalWidth;
   localparam int unsigned HalfWidth    = NominalWidth - 1;
   localparam int unsigned OffsetWidth  = 17;
   localparam int unsigned QueueDepth   = 2;

   // Multiplying by this and shifting right gives an exact divide by three
   // for any operand below 2^16.
   localparam logic [15:0] Recip3      = 16'hAAAB;
   localparam int unsigned Recip3Shift = 17;

   // Reset values of the configuration registers.
   localparam logic [NominalWidth-1:0] NominalWidthReset  = 12'd1190;
   localparam logic [NominalWidth-1:0] NominalHeightReset = 12'd614;

   // Configuration register indexes.
   typedef enum logic {
      CSR_TILE_WIDTH  = 1'b0,
      CSR_TILE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [NominalWidth-1:0] nominal_w;
      logic [NominalWidth-1:0] nominal_h;
   } cfg_type;

   // One image worth of grid geometry, handed from front to back.
   typedef struct packed {
      logic [SizeWidth-1:0]  image_w;
      logic [SizeWidth-1:0]  image_h;
      logic [CountWidth-1:0] cols;
      logic [CountWidth-1:0] rows;
      logic [StepWidth-1:0]  step_w;
      logic [StepWidth-1:0]  step_h;
      logic [StepWidth-1:0]  inner_w;
      logic [StepWidth-1:0]  inner_h;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [SizeWidth-1:0]    x;
      logic [SizeWidth-1:0]    y;
      logic [StepWidth-1:0]    w;
      logic [StepWidth-1:0]    h;
      logic [TileNumWidth-1:0] number;
      logic                    last;
   } tile_type;

   // Rounds the quotient up when the remainder exceeds half the nominal
   // size, then clamps the count to one through the largest grid side.
   function automatic logic [CountWidth-1:0] grid_count(
      input logic [DivWidth-1:0]   quot,
      input logic [DivWidth-1:0]   rem,
      input logic [HalfWidth-1:0]  half,
      input logic [CountWidth-1:0] max_side
   );
      logic [DivWidth:0] n;
      n = {1'b0, quot};
      if (rem > DivWidth'(half)) begin
         n = n + 1'b1;
      end
      if (n == '0) begin
         n = (DivWidth+1)'(1);
      end
      if (n > (DivWidth+1)'(max_side)) begin
         n = (DivWidth+1)'(max_side);
      end
      return n[CountWidth-1:0];
   endfunction

endpackage

// ----- design/overlapping_tile_grid_generator.sv -----
// Top level of the overlapping tile grid generator.
// Each request carries an image size and yields one response per tile of an
// overlapping grid, in row-major order, with tlast on the final tile. The
// front end uses four 13-bit divisions on one shared serial divider, plus
// set-up and hand-over states; a division by a zero two-thirds nominal size
// is skipped. The back end then emits one tile per cycle while the response
// channel accepts them, and a request yields columns times rows responses.
// A two-entry queue lets the front end work on the next request while the
// back end still emits tiles.
`timescale 1ns / 1ps

module overlapping_tile_grid_generator #(
   parameter int unsigned MAX_GRID_SIDE = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0: image_width[12:0], image_height[25:13].
   input  logic [31:0]            req_tdata,
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0: tile_x[12:0], tile_y[25:13], tile_w[39:26],
   // tile_h[53:40], tile_number[59:54].
   output logic [63:0]            rsp_tdata,
   output logic                   rsp_tlast,
   // Configuration port.
   input  logic                   csr_we,
   input  otg_pkg::csr_index_type csr_index,
   input  logic [11:0]            csr_wdata
);
   import otg_pkg::*;

`include "overlapping_tile_grid_generator_assert.svh"

   localparam logic [CountWidth-1:0] MaxSide = CountWidth'(MAX_GRID_SIDE);

   cfg_type          cfg_ff, cfg_in;
   push_type         push;
   job_type          head;
   queue_status_type q_status;
   logic             pop;
   tile_type         tile;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TILE_WIDTH:  cfg_in.nominal_w = csr_wdata;
            CSR_TILE_HEIGHT: cfg_in.nominal_h = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nominal_w <= NominalWidthReset;
         cfg_ff.nominal_h <= NominalHeightReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   otg_front #(
      .MaxSide (MaxSide)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_image_w (req_tdata[12:0]),
      .req_image_h (req_tdata[25:13]),
      .push        (push),
      .q_status    (q_status)
   );

   otg_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   otg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .tile_valid (rsp_tvalid),
      .tile_ready (rsp_tready),
      .tile       (tile)
   );

   // Response packing.
   assign rsp_tdata = {4'b0000, tile.number, tile.h, tile.w, tile.y, tile.x};
   assign rsp_tlast = tile.last;

   // A taken request keeps the front end busy for the following cycle.
   `OTG_ASSERT_NEXT(a_req_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   // A completed hand-over leaves the queue holding at least one grid.
   `OTG_ASSERT_NEXT(a_push_lands, clock, reset, push.valid && !q_status.full,
                    !q_status.empty)
   // After the final tile of a grid, the next response starts a new grid.
   `OTG_ASSERT_NEXT(a_grid_restart, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
                    !rsp_tvalid || rsp_tdata[59:54] == 6'd0)

endmodule

// ----- design/otg_divider.sv -----
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module otg_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [otg_pkg::DivWidth-1:0]  dividend,
   input  logic [otg_pkg::DivWidth-1:0]  divisor,
   output logic                          done,
   output logic [otg_pkg::DivWidth-1:0]  quotient,
   output logic [otg_pkg::DivWidth-1:0]  remainder
);
   import otg_pkg::*;

   localparam int unsigned CntWidth = $clog2(DivWidth);
   localparam logic [CntWidth-1:0] LastStep = CntWidth'(DivWidth - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [DivWidth-1:0] rem_ff, rem_in;
   logic [DivWidth-1:0] quot_ff, quot_in;
   logic [DivWidth-1:0] divisor_ff, divisor_in;
   logic [DivWidth:0]   shifted;
   logic [DivWidth:0]   diff;
   logic                fits;

   // One trial subtraction of the shifted partial remainder.
   assign shifted = {rem_ff, quot_ff[DivWidth-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quot_in    = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DivWidth-1:0] : shifted[DivWidth-1:0];
         quot_in = {quot_ff[DivWidth-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

// ----- design/otg_front.sv -----
// Front end: accepts an image size and works out the grid geometry.
`timescale 1ns / 1ps

module otg_front #(
   parameter logic [3:0] MaxSide = 4'd8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  otg_pkg::cfg_type                   cfg,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [otg_pkg::SizeWidth-1:0]      req_image_w,
   input  logic [otg_pkg::SizeWidth-1:0]      req_image_h,
   output otg_pkg::push_type                  push,
   input  otg_pkg::queue_status_type          q_status
);
   import otg_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_PREP   = 8'b0000_0010,
      ST_CNT_W  = 8'b0000_0100,
      ST_CNT_H  = 8'b0000_1000,
      ST_STEP_W = 8'b0001_0000,
      ST_STEP_H = 8'b0010_0000,
      ST_INNER  = 8'b0100_0000,
      ST_PUSH   = 8'b1000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic                   launched_ff, launched_in;
   logic [SizeWidth-1:0]   img_w_ff, img_w_in;
   logic [SizeWidth-1:0]   img_h_ff, img_h_in;
   logic [ThirdWidth-1:0]  third_w_ff, third_w_in;
   logic [ThirdWidth-1:0]  third_h_ff, third_h_in;
   logic [HalfWidth-1:0]   half_w_ff, half_w_in;
   logic [HalfWidth-1:0]   half_h_ff, half_h_in;
   logic [CountWidth-1:0]  cols_ff, cols_in;
   logic [CountWidth-1:0]  rows_ff, rows_in;
   logic [StepWidth-1:0]   step_w_ff, step_w_in;
   logic [StepWidth-1:0]   step_h_ff, step_h_in;
   logic [StepWidth-1:0]   inner_w_ff, inner_w_in;
   logic [StepWidth-1:0]   inner_h_ff, inner_h_in;

   logic [28:0]            third_w_prod, third_h_prod;
   logic [31:0]            inner_w_prod, inner_h_prod;
   logic                   div_start;
   logic [DivWidth-1:0]    div_dividend, div_divisor;
   logic                   div_done;
   logic [DivWidth-1:0]    div_quot, div_rem;
   logic [StepWidth-1:0]   step_from_quot;

   // Two thirds of each nominal size, as twice the size divided by three.
   assign third_w_prod = 29'({cfg.nominal_w, 1'b0}) * 29'(Recip3);
   assign third_h_prod = 29'({cfg.nominal_h, 1'b0}) * 29'(Recip3);

   // Inner tile length is four thirds of the step.
   assign inner_w_prod = 32'({step_w_ff, 2'b00}) * 32'(Recip3);
   assign inner_h_prod = 32'({step_h_ff, 2'b00}) * 32'(Recip3);

   assign step_from_quot = StepWidth'(div_quot) + 1'b1;

   // Operand selection for the shared divider.
   always_comb begin
      unique case (state_ff)
         ST_CNT_W: begin
            div_dividend = img_w_ff;
            div_divisor  = DivWidth'(third_w_ff);
         end
         ST_CNT_H: begin
            div_dividend = img_h_ff;
            div_divisor  = DivWidth'(third_h_ff);
         end
         ST_STEP_W: begin
            div_dividend = img_w_ff;
            div_divisor  = DivWidth'(cols_ff);
         end
         ST_STEP_H: begin
            div_dividend = img_h_ff;
            div_divisor  = DivWidth'(rows_ff);
         end
         default: begin
            div_dividend = img_w_ff;
            div_divisor  = DivWidth'(cols_ff);
         end
      endcase
   end

   // Sequencer over the four divisions.
   always_comb begin
      state_in    = state_ff;
      launched_in = launched_ff;
      img_w_in    = img_w_ff;
      img_h_in    = img_h_ff;
      third_w_in  = third_w_ff;
      third_h_in  = third_h_ff;
      half_w_in   = half_w_ff;
      half_h_in   = half_h_ff;
      cols_in     = cols_ff;
      rows_in     = rows_ff;
      step_w_in   = step_w_ff;
      step_h_in   = step_h_ff;
      inner_w_in  = inner_w_ff;
      inner_h_in  = inner_h_ff;
      div_start   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               img_w_in = req_image_w;
               img_h_in = req_image_h;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            third_w_in = third_w_prod[Recip3Shift +: ThirdWidth];
            third_h_in = third_h_prod[Recip3Shift +: ThirdWidth];
            half_w_in  = cfg.nominal_w[NominalWidth-1:1];
            half_h_in  = cfg.nominal_h[NominalWidth-1:1];
            state_in   = ST_CNT_W;
         end
         ST_CNT_W: begin
            if (third_w_ff == '0) begin
               cols_in  = MaxSide;
               state_in = ST_CNT_H;
            end else if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               cols_in     = grid_count(div_quot, div_rem, half_w_ff, MaxSide);
               launched_in = 1'b0;
               state_in    = ST_CNT_H;
            end
         end
         ST_CNT_H: begin
            if (third_h_ff == '0) begin
               rows_in  = MaxSide;
               state_in = ST_STEP_W;
            end else if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               rows_in     = grid_count(div_quot, div_rem, half_h_ff, MaxSide);
               launched_in = 1'b0;
               state_in    = ST_STEP_W;
            end
         end
         ST_STEP_W: begin
            if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               step_w_in   = step_from_quot;
               launched_in = 1'b0;
               state_in    = ST_STEP_H;
            end
         end
         ST_STEP_H: begin
            if (!launched_ff) begin
               div_start   = 1'b1;
               launched_in = 1'b1;
            end else if (div_done) begin
               step_h_in   = step_from_quot;
               launched_in = 1'b0;
               state_in    = ST_INNER;
            end
         end
         ST_INNER: begin
            inner_w_in = inner_w_prod[Recip3Shift +: StepWidth];
            inner_h_in = inner_h_prod[Recip3Shift +: StepWidth];
            state_in   = ST_PUSH;
         end
         ST_PUSH: begin
            if (!q_status.full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         launched_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
      end
   end

   // Geometry registers.
   always_ff @(posedge clock) begin
      img_w_ff   <= img_w_in;
      img_h_ff   <= img_h_in;
      third_w_ff <= third_w_in;
      third_h_ff <= third_h_in;
      half_w_ff  <= half_w_in;
      half_h_ff  <= half_h_in;
      cols_ff    <= cols_in;
      rows_ff    <= rows_in;
      step_w_ff  <= step_w_in;
      step_h_ff  <= step_h_in;
      inner_w_ff <= inner_w_in;
      inner_h_ff <= inner_h_in;
   end

   otg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign push.valid       = (state_ff == ST_PUSH);
   assign push.job.image_w = img_w_ff;
   assign push.job.image_h = img_h_ff;
   assign push.job.cols    = cols_ff;
   assign push.job.rows    = rows_ff;
   assign push.job.step_w  = step_w_ff;
   assign push.job.step_h  = step_h_ff;
   assign push.job.inner_w = inner_w_ff;
   assign push.job.inner_h = inner_h_ff;

endmodule

// ----- design/otg_queue.sv -----
// Two-entry queue of grid descriptions between the front and the back.
`timescale 1ns / 1ps

module otg_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  otg_pkg::push_type         push,
   input  logic                      pop,
   output otg_pkg::job_type          head,
   output otg_pkg::queue_status_type status
);
   import otg_pkg::*;

   localparam int unsigned PtrWidth   = $clog2(QueueDepth);
   localparam int unsigned LevelWidth = $clog2(QueueDepth + 1);

   job_type               mem_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LevelWidth-1:0] level_ff, level_in;
   logic                  do_push, do_pop;

   assign status.full  = (level_ff == LevelWidth'(QueueDepth));
   assign status.empty = (level_ff == '0);
   assign do_push      = push.valid && !status.full;
   assign do_pop       = pop && !status.empty;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

   assign head = mem_ff[rd_ptr_ff];

endmodule

// ----- design/otg_back.sv -----
// Back end: walks the grid, emitting a tile rectangle per cycle when not stalled.
`timescale 1ns / 1ps

module otg_back (
   input  logic                      clock,
   input  logic                      reset,
   input  otg_pkg::job_type          head,
   input  otg_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      tile_valid,
   input  logic                      tile_ready,
   output otg_pkg::tile_type         tile
);
   import otg_pkg::*;

   logic                     busy_ff, busy_in;
   job_type                  job_ff, job_in;
   logic [CountWidth-1:0]    col_ff, col_in;
   logic [CountWidth-1:0]    row_ff, row_in;
   logic [OffsetWidth-1:0]   x_ff, x_in;
   logic [OffsetWidth-1:0]   y_ff, y_in;
   logic [TileNumWidth-1:0]  num_ff, num_in;
   logic                     valid_ff, valid_in;
   tile_type                 tile_ff, tile_in;

   logic                     advance;
   logic                     last_col, last_row;
   logic [OffsetWidth-1:0]   size_w, size_h;
   logic [OffsetWidth-1:0]   edge_w, edge_h;

   assign pop      = !busy_ff && !q_status.empty;
   assign advance  = busy_ff && (!valid_ff || tile_ready);
   assign last_col = (col_ff == job_ff.cols - 1'b1);
   assign last_row = (row_ff == job_ff.rows - 1'b1);
   assign size_w   = OffsetWidth'(job_ff.image_w);
   assign size_h   = OffsetWidth'(job_ff.image_h);

   // Length left to the image edge, zero when the offset lies beyond it.
   assign edge_w = (x_ff <= size_w) ? size_w - x_ff : '0;
   assign edge_h = (y_ff <= size_h) ? size_h - y_ff : '0;

   always_comb begin
      busy_in  = busy_ff;
      job_in   = job_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      num_in   = num_ff;
      valid_in = valid_ff;
      tile_in  = tile_ff;
      if (tile_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         // Start a new grid from its top-left tile.
         job_in  = head;
         col_in  = '0;
         row_in  = '0;
         x_in    = '0;
         y_in    = '0;
         num_in  = '0;
         busy_in = 1'b1;
      end else if (advance) begin
         tile_in.x      = x_ff[SizeWidth-1:0];
         tile_in.y      = y_ff[SizeWidth-1:0];
         tile_in.w      = last_col ? edge_w[StepWidth-1:0] : job_ff.inner_w;
         tile_in.h      = last_row ? edge_h[StepWidth-1:0] : job_ff.inner_h;
         tile_in.number = num_ff;
         tile_in.last   = last_col && last_row;
         valid_in       = 1'b1;
         num_in         = num_ff + 1'b1;
         if (last_col) begin
            col_in = '0;
            x_in   = '0;
            row_in = row_ff + 1'b1;
            y_in   = y_ff + OffsetWidth'(job_ff.step_h);
            if (last_row) begin
               busy_in = 1'b0;
            end
         end else begin
            col_in = col_ff + 1'b1;
            x_in   = x_ff + OffsetWidth'(job_ff.step_w);
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   // Walk position and output register.
   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      num_ff  <= num_in;
      tile_ff <= tile_in;
   end

   assign tile_valid = valid_ff;
   assign tile       = tile_ff;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the overlapping tile grid generator.
`timescale 1ns / 1ps

module tb_top;
   import otg_pkg::*;

   localparam int unsigned MaxSide        = 8;
   localparam int unsigned CycleLimit     = 1_000_000;
   localparam int unsigned TailCycles     = 200;
   localparam int unsigned ItemsPerPhase  = 63;
   localparam int unsigned HoldOffCycles  = 600;
   localparam int unsigned ReportLimit    = 10;

   // One tile rectangle as it travels on the response channel.
   typedef struct packed {
      logic [12:0] x;
      logic [12:0] y;
      logic [13:0] w;
      logic [13:0] h;
      logic [5:0]  number;
      logic        last;
   } tile_rect_type;

   // Predicts the tile grid of each accepted request and checks the responses.
   class tile_scoreboard;
      tile_rect_type expected_tiles[$];
      int unsigned   nominal_w = 1190;
      int unsigned   nominal_h = 614;
      int unsigned   cols, rows, step_w, step_h;
      int unsigned   requests_seen, tiles_checked, failures;

      function void set_nominal(input csr_index_type idx, input logic [11:0] value);
         if (idx == CSR_TILE_WIDTH) begin
            nominal_w = value;
         end else begin
            nominal_h = value;
         end
      endfunction

      // Grid side: size over two thirds of the nominal, rounded up past half the
      // nominal, then held within one and the largest side; a zero two-thirds nominal gives the largest side.
      function int unsigned grid_side(input int unsigned size, input int unsigned nominal);
         int unsigned third2, n;
         third2 = nominal * 2 / 3;
         if (third2 == 0) begin
            return MaxSide;
         end
         n = size / third2;
         if (size % third2 > nominal / 2) begin
            n = n + 1;
         end
         if (n < 1) begin
            n = 1;
         end
         if (n > MaxSide) begin
            n = MaxSide;
         end
         return n;
      endfunction

      function void note_request(input logic [12:0] img_w, input logic [12:0] img_h);
         int unsigned   r, c, x, y, tw, th, k;
         tile_rect_type t;
         requests_seen++;
         cols   = grid_side(img_w, nominal_w);
         rows   = grid_side(img_h, nominal_h);
         step_w = (img_w / cols + 1) & 14'h3FFF;
         step_h = (img_h / rows + 1) & 14'h3FFF;
         k = 0;
         for (r = 0; r < rows; r++) begin
            for (c = 0; c < cols; c++) begin
               x = step_w * c;
               y = step_h * r;
               // The last column and row reach the image edge, never below zero.
               if (c == cols - 1) begin
                  tw = (x <= img_w) ? img_w - x : 0;
               end else begin
                  tw = step_w * 4 / 3;
               end
               if (r == rows - 1) begin
                  th = (y <= img_h) ? img_h - y : 0;
               end else begin
                  th = step_h * 4 / 3;
               end
               t.x      = 13'(x);
               t.y      = 13'(y);
               t.w      = 14'(tw);
               t.h      = 14'(th);
               t.number = 6'(k);
               t.last   = (r == rows - 1) && (c == cols - 1);
               expected_tiles = {expected_tiles, t};
               k++;
            end
         end
      endfunction

      function void check_tile(input logic [63:0] data, input logic last);
         tile_rect_type got, want;
         got.x      = data[12:0];
         got.y      = data[25:13];
         got.w      = data[39:26];
         got.h      = data[53:40];
         got.number = data[59:54];
         got.last   = last;
         tiles_checked++;
         if (expected_tiles.size() == 0) begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("Unexpected tile: x %0d y %0d w %0d h %0d number %0d last %0b",
                        got.x, got.y, got.w, got.h, got.number, got.last);
            end
            return;
         end
         want = expected_tiles.pop_front();
         if (got.x != want.x || got.y != want.y || got.w != want.w || got.h != want.h ||
             got.number != want.number || got.last != want.last) begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("Tile mismatch: expected x %0d y %0d w %0d h %0d number %0d last %0b",
                        want.x, want.y, want.w, want.h, want.number, want.last);
               $display("               actual   x %0d y %0d w %0d h %0d number %0d last %0b",
                        got.x, got.y, got.w, got.h, got.number, got.last);
            end
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [31:0]   req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [63:0]   rsp_tdata;
   logic          rsp_tlast;
   logic          csr_we;
   csr_index_type csr_index;
   logic [11:0]   csr_wdata;

   tile_scoreboard sb;
   int unsigned    send_idle_pct;
   int unsigned    recv_idle_pct;
   int unsigned    rsp_hold_cycles;
   int unsigned    cycle_count;
   int unsigned    settings_used;

   overlapping_tile_grid_generator #(.MAX_GRID_SIDE(MaxSide)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit, in case the block stops answering.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles with %0d tiles outstanding.",
                  cycle_count, sb.expected_tiles.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: a long hold-off when asked, otherwise random back-pressure.
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every accepted response goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_tile(rsp_tdata, rsp_tlast);
      end
   end

   // Offers one request, with random idle cycles before it, and waits until
   // it is accepted. Called and returns at a falling edge.
   task automatic send_request(input logic [12:0] img_w, input logic [12:0] img_h);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, img_h, img_w};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.note_request(img_w, img_h);
      @(negedge clock);
   endtask

   // Stops offering requests and waits until every expected tile has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do begin
         @(negedge clock);
      end while (sb.expected_tiles.size() != 0);
   endtask

   // Writes both nominal tile sizes while the block is idle.
   task automatic set_tile_size(input logic [11:0] nom_w, input logic [11:0] nom_h);
      csr_we    <= 1'b1;
      csr_index <= CSR_TILE_WIDTH;
      csr_wdata <= nom_w;
      @(negedge clock);
      csr_index <= CSR_TILE_HEIGHT;
      csr_wdata <= nom_h;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_nominal(CSR_TILE_WIDTH, nom_w);
      sb.set_nominal(CSR_TILE_HEIGHT, nom_h);
      settings_used++;
   endtask

   // Image size biased towards small images and the rounding boundary.
   function automatic logic [12:0] random_size(input int unsigned nominal);
      int unsigned pick, third2, k;
      int          v;
      pick   = $urandom_range(99);
      third2 = nominal * 2 / 3;
      if (pick < 45) begin
         return 13'($urandom_range(8191));
      end
      if (pick < 65 || third2 == 0) begin
         return 13'($urandom_range(63));
      end
      k = $urandom_range(9);
      v = int'(k * third2 + nominal / 2) + int'($urandom_range(3)) - 1;
      if (v < 0 || v > 8191) begin
         return 13'($urandom_range(8191));
      end
      return 13'(v);
   endfunction

   // Main sequence.
   initial begin
      int unsigned phase;
      sb              = new();
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      rsp_tready      = 1'b0;
      csr_we          = 1'b0;
      csr_index       = CSR_TILE_WIDTH;
      csr_wdata       = '0;
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      rsp_hold_cycles = 0;
      cycle_count     = 0;
      settings_used   = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests on the reset sizes: zero size, extremes, and both
      // sides of the rounding boundary and of the largest side.
      send_request(13'd0, 13'd0);
      send_request(13'd1, 13'd1);
      send_request(13'd8191, 13'd8191);
      send_request(13'd8191, 13'd0);
      send_request(13'd0, 13'd8191);
      send_request(13'd793, 13'd409);
      send_request(13'd1388, 13'd716);
      send_request(13'd1389, 13'd717);
      send_request(13'd1585, 13'd817);
      send_request(13'd7137, 13'd3681);
      send_request(13'h0AAA, 13'h1555);
      send_request(13'h1555, 13'h0AAA);

      // Tiny nominal sizes saturate the grid, so the edge tiles start
      // beyond a small image and shrink to nothing.
      wait_drained();
      set_tile_size(12'd1, 12'd0);
      send_request(13'd3, 13'd5);
      send_request(13'd0, 13'd0);
      send_request(13'd7, 13'd7);
      send_request(13'd8191, 13'd8191);

      // Largest nominal sizes.
      wait_drained();
      set_tile_size(12'hFFF, 12'hFFF);
      send_request(13'd8191, 13'd8191);
      send_request(13'd2730, 13'd4777);
      send_request(13'd4778, 13'd1);

      // Random requests over several size settings and idling patterns.
      for (phase = 0; phase < 6; phase++) begin
         wait_drained();
         case (phase)
            0: set_tile_size(12'd1190, 12'd614);
            1: set_tile_size(12'hFFF, 12'd3);
            2: set_tile_size(12'($urandom_range(3, 4095)), 12'($urandom_range(3, 600)));
            3: set_tile_size(12'd3, 12'd2);
            4: set_tile_size(12'($urandom_range(3, 1500)), 12'($urandom_range(3, 4095)));
            default: set_tile_size(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
         endcase
         if (phase < 2) begin
            send_idle_pct = 18;
            recv_idle_pct = 47;
         end else if (phase < 4) begin
            send_idle_pct = 47;
            recv_idle_pct = 18;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // Hold the response side off so the block fills and stalls requests.
         if (phase == 0) begin
            rsp_hold_cycles = HoldOffCycles;
         end
         repeat (ItemsPerPhase) begin
            send_request(random_size(sb.nominal_w), random_size(sb.nominal_h));
         end
      end

      wait_drained();
      repeat (TailCycles) @(negedge clock);

      $display("Checked %0d tiles from %0d image sizes over %0d nominal size settings,",
               sb.tiles_checked, sb.requests_seen, settings_used);
      $display("including zero sizes, saturated grids and a long response hold-off.");
      if (sb.failures == 0 && sb.expected_tiles.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d failures, %0d tiles never received.",
                  sb.failures, sb.expected_tiles.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/otg_pkg.sv
design/otg_divider.sv
design/otg_front.sv
design/otg_queue.sv
design/otg_back.sv
design/overlapping_tile_grid_generator.sv
tb/sv/tb_top.sv
